/* rtl/core/gbn_pkg.sv */
// Package for the greedy box suppression block: widths, constants and the
// command and status bundles between controller and datapath.
// No dependencies.
package gbn_pkg;

    localparam int MAX_BOXES  = 64;
    localparam int IDX_W      = $clog2(MAX_BOXES);
    localparam int CNT_W      = IDX_W + 1;
    localparam int COORD_BITS = 12;
    localparam int SIZE_BITS  = COORD_BITS - 1;
    localparam int SCORE_BITS = 16;
    localparam int GEOM_W     = 2 * COORD_BITS + 2 * SIZE_BITS;
    localparam int AREA_W     = 2 * SIZE_BITS;
    localparam int UNI_W      = AREA_W + 1;
    localparam int THR_W      = 16;
    localparam int PROD_W     = UNI_W + THR_W;

    // Configuration register indexes.
    localparam logic REG_SCORE_THR   = 1'b0;
    localparam logic REG_OVERLAP_THR = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [THR_W-1:0] SCORE_THR_RST   = 16'd16384;
    localparam logic [THR_W-1:0] OVERLAP_THR_RST = 16'd29491;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             load;       // an input item is accepted this cycle
        logic             scan_start; // clear the best candidate
        logic             scan_issue; // read the score store at addr
        logic             iou_issue;  // read the geometry store at addr for overlap
        logic [IDX_W-1:0] addr;
        logic             keep;       // keep the best candidate
        logic             out_load;   // load the output register
        logic             out_final;  // output register gets the closing item
        logic             clear_set;  // reset per-set state
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             pipe_busy;
        logic             best_valid;
        logic             best_ok;
        logic             pending_valid;
        logic             out_free;
    } status_t;

endpackage

/* rtl/core/gbn_datapath.sv */
// Datapath of the greedy box suppression block: box stores, candidate search,
// overlap pipeline, suppression mask and output register.
// Depends on gbn_pkg.
module gbn_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  gbn_pkg::cmd_t                       cmd,
    output gbn_pkg::status_t                    status,
    input  logic [gbn_pkg::COORD_BITS-1:0]      box_left,
    input  logic [gbn_pkg::COORD_BITS-1:0]      box_top,
    input  logic [gbn_pkg::SIZE_BITS-1:0]       box_width,
    input  logic [gbn_pkg::SIZE_BITS-1:0]       box_height,
    input  logic [gbn_pkg::SCORE_BITS-1:0]      confidence,
    input  logic                                cfg_wr_en,
    input  logic                                cfg_index,
    input  logic [gbn_pkg::THR_W-1:0]           cfg_wdata,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [gbn_pkg::IDX_W-1:0]           out_index,
    output logic                                out_none,
    output logic                                out_ovf,
    output logic                                out_last
);
    import gbn_pkg::*;

    logic [GEOM_W-1:0]     geom_mem [MAX_BOXES];
    logic [SCORE_BITS-1:0] score_mem [MAX_BOXES];

    logic [THR_W-1:0]      score_thr_reg, overlap_thr_reg;
    logic [CNT_W-1:0]      count_reg;
    logic                  ovf_reg;
    logic [MAX_BOXES-1:0]  done_reg;

    logic [GEOM_W-1:0]     geom_rd_reg;
    logic [SCORE_BITS-1:0] score_rd_reg;
    logic [IDX_W-1:0]      rd_idx_reg;
    logic                  rd_scan_reg, rd_iou_reg;

    logic                  best_valid_reg;
    logic [SCORE_BITS-1:0] best_score_reg;
    logic [IDX_W-1:0]      best_idx_reg;
    logic [GEOM_W-1:0]     best_geom_reg;
    logic [AREA_W-1:0]     area_a_reg;

    logic                  pend_valid_reg;
    logic [IDX_W-1:0]      pend_idx_reg;

    logic                  p1_v_reg, p2_v_reg, p3_v_reg, p4_v_reg;
    logic [IDX_W-1:0]      p1_idx_reg, p2_idx_reg, p3_idx_reg, p4_idx_reg;
    logic [SIZE_BITS-1:0]  p1_iw_reg, p1_ih_reg, p1_w_reg, p1_h_reg;
    logic [AREA_W-1:0]     p2_inter_reg, p2_area_reg, p3_inter_reg, p4_inter_reg;
    logic [UNI_W-1:0]      p3_uni_reg;
    logic [PROD_W-1:0]     p4_prod_reg;
    logic                  p4_uni_nz_reg;

    logic                  m_valid_reg;
    logic [IDX_W-1:0]      m_index_reg;
    logic                  m_none_reg, m_ovf_reg, m_last_reg;

    logic                  out_free;
    logic                  scan_take;
    logic                  hit;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            score_thr_reg   <= SCORE_THR_RST;
            overlap_thr_reg <= OVERLAP_THR_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_SCORE_THR:   score_thr_reg   <= cfg_wdata;
                REG_OVERLAP_THR: overlap_thr_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Box stores: one write port during loading, one registered read port.
    always_ff @(posedge aclk) begin
        if (cmd.load && count_reg < CNT_W'(MAX_BOXES)) begin
            geom_mem[count_reg[IDX_W-1:0]] <= {box_height, box_width, box_top, box_left};
            score_mem[count_reg[IDX_W-1:0]] <= confidence;
        end
        geom_rd_reg  <= geom_mem[cmd.addr];
        score_rd_reg <= score_mem[cmd.addr];
        rd_idx_reg   <= cmd.addr;
    end

    // Fill count and overflow flag of the current set.
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear_set) begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end else if (cmd.load) begin
            if (count_reg < CNT_W'(MAX_BOXES)) begin
                count_reg <= count_reg + 1'b1;
            end else begin
                ovf_reg <= 1'b1;
            end
        end
    end

    // Valid bits of the read stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_scan_reg <= 1'b0;
            rd_iou_reg  <= 1'b0;
        end else begin
            rd_scan_reg <= cmd.scan_issue;
            rd_iou_reg  <= cmd.iou_issue;
        end
    end

    // Best candidate search: highest score, lowest index on ties.
    assign scan_take = rd_scan_reg && !done_reg[rd_idx_reg] &&
                       (!best_valid_reg || score_rd_reg > best_score_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.scan_start) begin
            best_valid_reg <= 1'b0;
        end else if (scan_take) begin
            best_valid_reg <= 1'b1;
        end
        if (scan_take) begin
            best_score_reg <= score_rd_reg;
            best_idx_reg   <= rd_idx_reg;
            best_geom_reg  <= geom_rd_reg;
        end
        area_a_reg <= best_geom_reg[2*COORD_BITS +: SIZE_BITS] *
                      best_geom_reg[2*COORD_BITS+SIZE_BITS +: SIZE_BITS];
    end

    // Overlap pipeline stage 1: intersection width and height.
    always_ff @(posedge aclk) begin
        logic signed [COORD_BITS+1:0] l1, l2, t1, t2, r1, r2, b1, b2;
        logic signed [COORD_BITS+1:0] ix, iy;
        l1 = (COORD_BITS+2)'(signed'(best_geom_reg[0 +: COORD_BITS]));
        t1 = (COORD_BITS+2)'(signed'(best_geom_reg[COORD_BITS +: COORD_BITS]));
        l2 = (COORD_BITS+2)'(signed'(geom_rd_reg[0 +: COORD_BITS]));
        t2 = (COORD_BITS+2)'(signed'(geom_rd_reg[COORD_BITS +: COORD_BITS]));
        r1 = l1 + signed'({3'b0, best_geom_reg[2*COORD_BITS +: SIZE_BITS]})
             - (COORD_BITS+2)'(1);
        b1 = t1 + signed'({3'b0, best_geom_reg[2*COORD_BITS+SIZE_BITS +: SIZE_BITS]})
             - (COORD_BITS+2)'(1);
        r2 = l2 + signed'({3'b0, geom_rd_reg[2*COORD_BITS +: SIZE_BITS]})
             - (COORD_BITS+2)'(1);
        b2 = t2 + signed'({3'b0, geom_rd_reg[2*COORD_BITS+SIZE_BITS +: SIZE_BITS]})
             - (COORD_BITS+2)'(1);
        ix = (r1 < r2 ? r1 : r2) - (l1 > l2 ? l1 : l2) + (COORD_BITS+2)'(1);
        iy = (b1 < b2 ? b1 : b2) - (t1 > t2 ? t1 : t2) + (COORD_BITS+2)'(1);
        p1_iw_reg  <= (ix > 0) ? ix[SIZE_BITS-1:0] : '0;
        p1_ih_reg  <= (iy > 0) ? iy[SIZE_BITS-1:0] : '0;
        p1_w_reg   <= geom_rd_reg[2*COORD_BITS +: SIZE_BITS];
        p1_h_reg   <= geom_rd_reg[2*COORD_BITS+SIZE_BITS +: SIZE_BITS];
        p1_idx_reg <= rd_idx_reg;
    end

    // Stages 2 to 4: intersection and area products, union, threshold product.
    always_ff @(posedge aclk) begin
        p2_inter_reg  <= p1_iw_reg * p1_ih_reg;
        p2_area_reg   <= p1_w_reg * p1_h_reg;
        p2_idx_reg    <= p1_idx_reg;
        p3_uni_reg    <= {1'b0, area_a_reg} + {1'b0, p2_area_reg} - {1'b0, p2_inter_reg};
        p3_inter_reg  <= p2_inter_reg;
        p3_idx_reg    <= p2_idx_reg;
        p4_prod_reg   <= overlap_thr_reg * p3_uni_reg;
        p4_uni_nz_reg <= p3_uni_reg != '0;
        p4_inter_reg  <= p3_inter_reg;
        p4_idx_reg    <= p3_idx_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_v_reg <= 1'b0;
            p2_v_reg <= 1'b0;
            p3_v_reg <= 1'b0;
            p4_v_reg <= 1'b0;
        end else begin
            p1_v_reg <= rd_iou_reg;
            p2_v_reg <= p1_v_reg;
            p3_v_reg <= p2_v_reg;
            p4_v_reg <= p3_v_reg;
        end
    end

    // Suppression test: intersection over union above the overlap threshold.
    assign hit = p4_v_reg && p4_uni_nz_reg &&
                 ({1'b0, p4_inter_reg, 16'b0} > p4_prod_reg);

    // Mask of boxes already kept or removed.
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear_set) begin
            done_reg <= '0;
        end else begin
            if (cmd.keep) begin
                done_reg[best_idx_reg] <= 1'b1;
            end
            if (hit) begin
                done_reg[p4_idx_reg] <= 1'b1;
            end
        end
    end

    // Kept box held back until it is known whether it closes the set.
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear_set) begin
            pend_valid_reg <= 1'b0;
        end else if (cmd.keep) begin
            pend_valid_reg <= 1'b1;
        end
        if (cmd.keep) begin
            pend_idx_reg <= best_idx_reg;
        end
    end

    // Output register.
    assign out_free = !m_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (out_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.out_load) begin
            m_index_reg <= pend_valid_reg ? pend_idx_reg : '0;
            m_none_reg  <= !pend_valid_reg;
            m_ovf_reg   <= ovf_reg;
            m_last_reg  <= cmd.out_final;
        end
    end

    assign out_valid = m_valid_reg;
    assign out_index = m_index_reg;
    assign out_none  = m_none_reg;
    assign out_ovf   = m_ovf_reg;
    assign out_last  = m_last_reg;

    assign status.count         = count_reg;
    assign status.pipe_busy     = rd_scan_reg | rd_iou_reg | p1_v_reg | p2_v_reg |
                                  p3_v_reg | p4_v_reg;
    assign status.best_valid    = best_valid_reg;
    assign status.best_ok       = best_score_reg >= score_thr_reg;
    assign status.pending_valid = pend_valid_reg;
    assign status.out_free      = out_free;

endmodule

/* rtl/core/gbn_ctrl.sv */
// Controller of the greedy box suppression block: loading, candidate search,
// overlap sweeps and the closing result.
// Depends on gbn_pkg.
module gbn_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    input  logic             in_last,
    output logic             in_ready,
    input  gbn_pkg::status_t status,
    output gbn_pkg::cmd_t    cmd
);
    import gbn_pkg::*;

    localparam logic [2:0] ST_LOAD       = 3'd0;
    localparam logic [2:0] ST_SCAN       = 3'd1;
    localparam logic [2:0] ST_SCAN_DRAIN = 3'd2;
    localparam logic [2:0] ST_KEEP       = 3'd3;
    localparam logic [2:0] ST_IOU        = 3'd4;
    localparam logic [2:0] ST_IOU_DRAIN  = 3'd5;
    localparam logic [2:0] ST_FINISH     = 3'd6;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             accept;
    logic             issue_more;

    assign in_ready   = state_reg == ST_LOAD;
    assign accept     = in_valid && in_ready;
    assign issue_more = cnt_reg < status.count;

    // Next state, sweep counter and commands.
    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        cmd            = '0;
        cmd.addr       = cnt_reg[IDX_W-1:0];
        cmd.load       = accept;
        unique case (state_reg)
            ST_LOAD: begin
                if (accept && in_last) begin
                    cmd.scan_start = 1'b1;
                    cnt_next       = '0;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan_issue = 1'b1;
                cnt_next       = cnt_reg + 1'b1;
                if (!(cnt_reg + 1'b1 < status.count)) begin
                    state_next = ST_SCAN_DRAIN;
                end
            end
            ST_SCAN_DRAIN: begin
                if (!status.pipe_busy) begin
                    state_next = (status.best_valid && status.best_ok) ? ST_KEEP : ST_FINISH;
                end
            end
            ST_KEEP: begin
                if (status.out_free) begin
                    cmd.keep     = 1'b1;
                    cmd.out_load = status.pending_valid;
                    cnt_next     = '0;
                    state_next   = ST_IOU;
                end
            end
            ST_IOU: begin
                cmd.iou_issue = issue_more;
                cnt_next      = cnt_reg + 1'b1;
                if (!(cnt_reg + 1'b1 < status.count)) begin
                    state_next = ST_IOU_DRAIN;
                end
            end
            ST_IOU_DRAIN: begin
                if (!status.pipe_busy) begin
                    cmd.scan_start = 1'b1;
                    cnt_next       = '0;
                    state_next     = ST_SCAN;
                end
            end
            ST_FINISH: begin
                if (status.out_free) begin
                    cmd.out_load  = 1'b1;
                    cmd.out_final = 1'b1;
                    cmd.clear_set = 1'b1;
                    state_next    = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

/* rtl/core/greedy_box_nms.sv */
// Greedy non-maximum suppression over up to 64 boxes per set.
// Throughput: boxes load one item per cycle while the block is in its loading state; the item
// with tlast closes the set. Per kept box the block runs one search sweep and one overlap sweep
// over the n boxes in the set, both through the single read port of the box store.
// Reset: synchronous, active low; clears control state and sets the thresholds to
// their defaults. The box stores are not cleared.
module greedy_box_nms (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,  // box_left, box_top, box_width, box_height, confidence
    input  logic        s_tlast,  // last_box
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,  // kept_index
    output logic [1:0]  m_tuser,  // none_kept, overflowed
    output logic        m_tlast,  // last_result
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata
);
    import gbn_pkg::*;

    cmd_t             cmd;
    status_t          status;
    logic [IDX_W-1:0] out_index;

    gbn_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_last  (s_tlast),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    gbn_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .status     (status),
        .box_left   (s_tdata[11:0]),
        .box_top    (s_tdata[23:12]),
        .box_width  (s_tdata[34:24]),
        .box_height (s_tdata[45:35]),
        .confidence (s_tdata[61:46]),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_index  (out_index),
        .out_none   (m_tuser[0]),
        .out_ovf    (m_tuser[1]),
        .out_last   (m_tlast)
    );

    assign m_tdata = {2'b00, out_index};

endmodule

/* tb/sv/tb_greedy_box_nms.sv */
// Testbench for greedy_box_nms: drives sets of candidate boxes, predicts the kept
// indices with a local greedy suppression model and checks every result item.
// Depends on gbn_pkg and the greedy_box_nms RTL.
`timescale 1ns / 1ps

module tb_greedy_box_nms;
    import gbn_pkg::*;

    localparam int LIMIT_CYCLES = 3000000;

    typedef struct packed {
        logic [15:0] confidence;
        logic [10:0] height;
        logic [10:0] width;
        logic [11:0] top;
        logic [11:0] left;
    } box_t;

    typedef struct packed {
        logic [5:0] kept_index;
        logic       none_kept;
        logic       overflowed;
        logic       last_result;
    } kept_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_index = REG_SCORE_THR;
    logic [15:0] cfg_wdata = '0;

    greedy_box_nms u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Predictor state: stored boxes of the open set and the thresholds.
    box_t        set_boxes[MAX_BOXES];
    int          set_count = 0;
    bit          set_overflow = 0;
    logic [15:0] score_thr = SCORE_THR_RST;
    logic [15:0] overlap_thr = OVERLAP_THR_RST;

    kept_t expected_kept[$];
    int    errors = 0;
    int    cycle = 0;
    int    send_idle_pct = 0;
    int    recv_stall_pct = 0;
    int    hold_off_cycles = 0;

    // Exact IoU test by cross multiplication on one pair of stored boxes.
    function automatic bit overlap_exceeds(box_t a, box_t b);
        longint ax, ay, aw, ah, bx, by, bw, bh, iw, ih, inter, uni, lo, hi;
        ax = longint'($signed(a.left)); ay = longint'($signed(a.top));
        bx = longint'($signed(b.left)); by = longint'($signed(b.top));
        aw = a.width; ah = a.height; bw = b.width; bh = b.height;
        hi = (ax + aw - 1 < bx + bw - 1) ? ax + aw - 1 : bx + bw - 1;
        lo = (ax > bx) ? ax : bx;
        iw = hi - lo + 1;
        if (iw < 0) iw = 0;
        hi = (ay + ah - 1 < by + bh - 1) ? ay + ah - 1 : by + bh - 1;
        lo = (ay > by) ? ay : by;
        ih = hi - lo + 1;
        if (ih < 0) ih = 0;
        inter = iw * ih;
        uni = aw * ah + bw * bh - inter;
        if (uni <= 0) return 1'b0;
        return inter * 65536 > longint'(overlap_thr) * uni;
    endfunction

    // Accept one box into the predictor; on the closing box run suppression.
    task automatic predict_box(box_t b, bit last);
        int order[MAX_BOXES];
        bit removed[MAX_BOXES];
        int i, j, n, a, kept;
        kept_t r;
        if (set_count < MAX_BOXES) begin
            set_boxes[set_count] = b;
            set_count++;
        end else begin
            set_overflow = 1;
        end
        if (!last) return;
        n = set_count;
        for (i = 0; i < n; i++) begin
            j = i;
            while (j > 0 && set_boxes[order[j-1]].confidence < set_boxes[i].confidence) begin
                order[j] = order[j-1];
                j--;
            end
            order[j] = i;
            removed[i] = 0;
        end
        kept = 0;
        for (i = 0; i < n; i++) begin
            a = order[i];
            if (removed[a] || set_boxes[a].confidence < score_thr) continue;
            r.kept_index = a[5:0];
            r.none_kept = 0;
            r.overflowed = set_overflow;
            r.last_result = 0;
            expected_kept.insert(expected_kept.size(), r);
            kept++;
            for (j = i + 1; j < n; j++)
                if (!removed[order[j]] && overlap_exceeds(set_boxes[a], set_boxes[order[j]]))
                    removed[order[j]] = 1;
        end
        if (kept == 0) begin
            r = '{kept_index: 6'd0, none_kept: 1'b1, overflowed: set_overflow, last_result: 1'b1};
            expected_kept.insert(expected_kept.size(), r);
        end else begin
            expected_kept[expected_kept.size() - 1].last_result = 1'b1;
        end
        set_count = 0;
        set_overflow = 0;
    endtask

    // Result checker.
    always @(posedge aclk) begin
        kept_t got, exp;
        cycle <= cycle + 1;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{kept_index: m_tdata[5:0], none_kept: m_tuser[0],
                    overflowed: m_tuser[1], last_result: m_tlast};
            if (expected_kept.size() == 0) begin
                $error("unexpected result item: index %0d", got.kept_index);
                errors++;
            end else begin
                exp = expected_kept.pop_front();
                if (got.none_kept != exp.none_kept) begin
                    $error("none_kept: expected %0d, actual %0d", exp.none_kept, got.none_kept);
                    errors++;
                end
                if (!exp.none_kept && got.kept_index != exp.kept_index) begin
                    $error("kept_index: expected %0d, actual %0d",
                           exp.kept_index, got.kept_index);
                    errors++;
                end
                if (got.overflowed != exp.overflowed) begin
                    $error("overflowed: expected %0d, actual %0d",
                           exp.overflowed, got.overflowed);
                    errors++;
                end
                if (got.last_result != exp.last_result) begin
                    $error("last_result: expected %0d, actual %0d",
                           exp.last_result, got.last_result);
                    errors++;
                end
            end
        end
    end

    // Receiver ready: random stalls, and a long hold-off counted down in cycles.
    always @(posedge aclk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Send one box, idling beforehand at random; returns once the item is taken.
    // Valid stays high after the item is taken so that the next item follows directly.
    task automatic send_box(box_t b, bit last);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, b};
        s_tlast <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_box(b, last);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_kept.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        if (idx == REG_SCORE_THR) score_thr = value;
        else overlap_thr = value;
    endtask

    function automatic box_t rand_box(bit clustered);
        box_t b;
        b = box_t'(62'({$urandom, $urandom}));
        if (clustered) begin
            b.left = 12'($signed($urandom_range(80)) - 40);
            b.top = 12'($signed($urandom_range(80)) - 40);
            b.width = 11'($urandom_range(120));
            b.height = 11'($urandom_range(120));
            if ($urandom_range(3) == 0) b.confidence = 16'($urandom_range(4)) * 16'h4000;
        end
        return b;
    endfunction

    // Random sets of mostly small sizes; a few reach or exceed capacity.
    task automatic random_sets(int items);
        int sent, n, i;
        bit cl;
        sent = 0;
        while (sent < items) begin
            case ($urandom_range(19))
                0: n = MAX_BOXES + $urandom_range(3);
                1: n = 1;
                default: n = 1 + $urandom_range(12);
            endcase
            cl = ($urandom_range(4) != 0);
            for (i = 0; i < n; i++) send_box(rand_box(cl), i == n - 1);
            sent += n;
        end
    endtask

    // Directed cases: each row is a box, last, and where check is set the
    // expected result of its one-box set.
    typedef struct {
        box_t  b;
        bit    last;
        bit    check;
        kept_t want;
    } row_t;

    initial begin
        row_t  rows[9];
        kept_t pred;
        int i;
        fork
            begin
                while (cycle < LIMIT_CYCLES) @(posedge aclk);
                $display("CHECKS FAILED");
                $finish;
            end
        join_none
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Extremes, a lone box, a low score, overlapping pair, zero area boxes.
        rows = '{
            '{'{16'hFFFF, 11'd2047, 11'd2047, 12'h800, 12'h800}, 1'b1,
              1'b1, '{6'd0, 1'b0, 1'b0, 1'b1}},
            '{'{16'h0000, 11'd0, 11'd0, 12'h7FF, 12'h7FF}, 1'b1,
              1'b1, '{6'd0, 1'b1, 1'b0, 1'b1}},
            '{'{16'd30000, 11'd10, 11'd10, 12'd0, 12'd0}, 1'b0, 1'b0, '0},
            '{'{16'd30000, 11'd10, 11'd10, 12'd1, 12'd1}, 1'b0, 1'b0, '0},
            '{'{16'd40000, 11'd10, 11'd10, 12'd100, 12'd100}, 1'b0, 1'b0, '0},
            '{'{16'd50000, 11'd0, 11'd0, 12'd0, 12'd0}, 1'b0, 1'b0, '0},
            '{'{16'd50000, 11'd0, 11'd0, 12'd0, 12'd0}, 1'b1, 1'b0, '0},
            '{'{16'h5555, 11'h555, 11'h2AA, 12'h555, 12'hAAA}, 1'b0, 1'b0, '0},
            '{'{16'hAAAA, 11'h2AA, 11'h555, 12'hAAA, 12'h555}, 1'b1, 1'b0, '0}
        };
        recv_stall_pct = 0;
        for (i = 0; i < 9; i++) begin
            send_box(rows[i].b, rows[i].last);
            if (rows[i].check) begin
                pred = expected_kept[expected_kept.size() - 1];
                if (pred.kept_index != rows[i].want.kept_index) begin
                    $error("kept_index: expected %0d, actual %0d",
                           rows[i].want.kept_index, pred.kept_index);
                    errors++;
                end
                if (pred.none_kept != rows[i].want.none_kept) begin
                    $error("none_kept: expected %0d, actual %0d",
                           rows[i].want.none_kept, pred.none_kept);
                    errors++;
                end
                if (pred.overflowed != rows[i].want.overflowed) begin
                    $error("overflowed: expected %0d, actual %0d",
                           rows[i].want.overflowed, pred.overflowed);
                    errors++;
                end
                if (pred.last_result != rows[i].want.last_result) begin
                    $error("last_result: expected %0d, actual %0d",
                           rows[i].want.last_result, pred.last_result);
                    errors++;
                end
            end
        end
        wait_drained();

        // Threshold extremes and the pressure phase with a long receiver hold-off.
        write_reg(REG_SCORE_THR, 16'd0);
        write_reg(REG_OVERLAP_THR, 16'd0);
        hold_off_cycles = 2000;
        for (i = 0; i < 20; i++) send_box(rand_box(1), i == 19);
        random_sets(30);
        wait_drained();
        write_reg(REG_SCORE_THR, 16'hFFFF);
        write_reg(REG_OVERLAP_THR, 16'hFFFF);
        random_sets(30);
        wait_drained();

        write_reg(REG_SCORE_THR, SCORE_THR_RST);
        write_reg(REG_OVERLAP_THR, OVERLAP_THR_RST);
        random_sets(110);
        send_idle_pct = 55;
        random_sets(90);
        wait_drained();
        write_reg(REG_SCORE_THR, 16'd8000);
        write_reg(REG_OVERLAP_THR, 16'd16000);
        send_idle_pct = 0;
        recv_stall_pct = 55;
        random_sets(90);
        send_idle_pct = 24;
        recv_stall_pct = 24;
        random_sets(90);
        wait_drained();

        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
